FILE: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/itmb_pkg.sv
package itmb_pkg;

    localparam logic [2:0] MODE_RX_BYTE = 3'd0;
    localparam logic [2:0] MODE_RD_REQ  = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_TX_WR   = 3'd3;
    localparam logic [2:0] MODE_SET_LEN = 3'd4;
    localparam logic [2:0] MODE_RX_RD   = 3'd5;

    localparam logic [1:0] NOTE_NONE  = 2'd0;
    localparam logic [1:0] NOTE_WRITE = 2'd1;
    localparam logic [1:0] NOTE_READ  = 2'd2;

    localparam logic [7:0] BYTE_FF     = 8'hFF;
    localparam int         TX_INIT_CNT = 4;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        K_NOP,
        K_RX_BYTE,
        K_RD_REQ,
        K_STOP,
        K_TX_WR,
        K_SET_LEN,
        K_RX_RD
    } t_kind;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_TX,
        SRC_RX,
        SRC_FF
    } t_src;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        first_byte;
        logic [9:0]  index;
        logic [10:0] length;
    } t_op;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [1:0]  notify;
        logic        rx_overflow;
        logic [10:0] rx_count;
    } t_result;

endpackage

FILE: rtl/itmb_ram.sv
module itmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/itmb_front.sv
module itmb_front #(
    parameter int BUF_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_hold,
    output logic             o_full,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_data,
    input  logic             i_first_byte,
    input  logic             i_bus_active,
    input  logic [9:0]       i_index,
    input  logic [10:0]      i_length,
    output logic             o_op_valid,
    output itmb_pkg::t_op    o_op,
    input  logic             i_take
);
    import itmb_pkg::*;

    t_op              r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wr;
    logic [FQ_AW-1:0] r_rd;
    logic [FQ_CW-1:0] r_cnt;
    logic [FQ_CW-1:0] n_cnt;
    t_op              w_op;
    logic             w_idx_ok;
    logic             w_push_ok;

    assign w_idx_ok = 32'(i_index) < 32'(BUF_DEPTH);

    // classify the request
    always_comb begin
        w_op.data       = i_data;
        w_op.first_byte = i_first_byte;
        w_op.index      = i_index;
        w_op.length     = (32'(i_length) > 32'(BUF_DEPTH)) ? 11'(BUF_DEPTH) : i_length;
        case (i_mode)
            MODE_RX_BYTE: w_op.kind = K_RX_BYTE;
            MODE_RD_REQ:  w_op.kind = i_bus_active ? K_RD_REQ : K_NOP;
            MODE_STOP:    w_op.kind = K_STOP;
            MODE_TX_WR:   w_op.kind = w_idx_ok ? K_TX_WR : K_NOP;
            MODE_SET_LEN: w_op.kind = K_SET_LEN;
            MODE_RX_RD:   w_op.kind = w_idx_ok ? K_RX_RD : K_NOP;
            default:      w_op.kind = K_NOP;
        endcase
    end

    assign o_full     = i_hold || (r_cnt == FQ_CW'(FQ_DEPTH));
    assign w_push_ok  = i_push && !o_full;
    assign o_op_valid = r_cnt != '0;
    assign o_op       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !i_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push_ok && i_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_take) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr] <= w_op;
        end
    end

endmodule

FILE: rtl/itmb_back.sv
module itmb_back #(
    parameter int BUF_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_op_valid,
    input  itmb_pkg::t_op              i_op,
    output logic                       o_take,
    input  logic [itmb_pkg::OQ_CW-1:0] i_outq_cnt,
    output logic                       o_res_valid,
    output itmb_pkg::t_result          o_res,
    output logic                       o_clr_busy
);
    import itmb_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    logic [CW-1:0] r_rx_fill,  n_rx_fill;
    logic [CW-1:0] r_tx_len,   n_tx_len;
    logic [CW-1:0] r_tx_pos,   n_tx_pos;
    logic          r_wr_act,   n_wr_act;
    logic          r_rd_act,   n_rd_act;
    logic          r_last_rd,  n_last_rd;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_s2_valid;
    t_src          r_s2_src,   n_src;
    logic [1:0]    r_s2_note,  n_note;
    logic          r_s2_ovf,   n_ovf;
    logic [10:0]   r_s2_count;

    logic          w_rx_we, w_rx_re, w_tx_we, w_tx_re;
    logic [AW-1:0] w_rx_waddr, w_rx_raddr, w_tx_waddr, w_tx_raddr;
    logic [7:0]    w_tx_wdata, w_rx_rdata, w_tx_rdata;
    logic [CW-1:0] w_base, w_pos;

    assign o_take = i_op_valid && !r_clr_busy &&
                    ((OQ_CW+1)'(i_outq_cnt) + (OQ_CW+1)'(r_s2_valid)
                     <= (OQ_CW+1)'(OQ_DEPTH - 2));

    always_comb begin
        n_rx_fill  = r_rx_fill;
        n_tx_len   = r_tx_len;
        n_tx_pos   = r_tx_pos;
        n_wr_act   = r_wr_act;
        n_rd_act   = r_rd_act;
        n_last_rd  = r_last_rd;
        n_src      = SRC_ZERO;
        n_note     = NOTE_NONE;
        n_ovf      = 1'b0;
        w_rx_we    = 1'b0;
        w_rx_re    = 1'b0;
        w_tx_we    = 1'b0;
        w_tx_re    = 1'b0;
        w_rx_waddr = '0;
        w_rx_raddr = AW'(i_op.index);
        w_tx_waddr = AW'(i_op.index);
        w_tx_wdata = i_op.data;
        w_tx_raddr = '0;
        w_base     = (!r_wr_act || i_op.first_byte) ? '0 : r_rx_fill;
        w_pos      = r_tx_pos;
        if (r_rd_act && (r_tx_pos < r_tx_len)) begin
            w_pos = r_tx_pos + 1'b1;
        end
        if (o_take) begin
            case (i_op.kind)
                K_RX_BYTE: begin
                    n_wr_act  = 1'b1;
                    n_last_rd = 1'b0;
                    if (!r_wr_act) begin
                        n_rd_act = 1'b0;
                    end
                    if (32'(w_base) < 32'(BUF_DEPTH)) begin
                        w_rx_we    = 1'b1;
                        w_rx_waddr = AW'(w_base);
                        n_rx_fill  = w_base + 1'b1;
                    end else begin
                        n_ovf     = 1'b1;
                        n_rx_fill = w_base;
                    end
                end
                K_RD_REQ: begin
                    n_tx_pos = w_pos;
                    if (!r_rd_act) begin
                        n_last_rd = 1'b1;
                        n_rd_act  = 1'b1;
                        n_wr_act  = 1'b0;
                    end
                    if (w_pos >= r_tx_len) begin
                        n_src = SRC_FF;
                    end else begin
                        n_last_rd  = 1'b1;
                        n_src      = SRC_TX;
                        w_tx_re    = 1'b1;
                        w_tx_raddr = AW'(w_pos);
                    end
                end
                K_STOP: begin
                    n_rd_act  = 1'b0;
                    n_wr_act  = 1'b0;
                    n_last_rd = 1'b0;
                    n_note    = r_last_rd ? NOTE_READ : NOTE_WRITE;
                end
                K_TX_WR: begin
                    w_tx_we = 1'b1;
                end
                K_SET_LEN: begin
                    n_tx_len = CW'(i_op.length);
                    n_tx_pos = '0;
                end
                K_RX_RD: begin
                    w_rx_re = 1'b1;
                    n_src   = SRC_RX;
                end
                default: begin
                end
            endcase
        end
        // tx store init sweep after reset
        if (r_clr_busy) begin
            w_tx_we    = 1'b1;
            w_tx_waddr = r_clr_addr;
            w_tx_wdata = (32'(r_clr_addr) < 32'(TX_INIT_CNT)) ? BYTE_FF : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_fill  <= '0;
            r_tx_len   <= CW'(TX_INIT_CNT);
            r_tx_pos   <= '0;
            r_wr_act   <= 1'b0;
            r_rd_act   <= 1'b0;
            r_last_rd  <= 1'b1;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_rx_fill  <= n_rx_fill;
            r_tx_len   <= n_tx_len;
            r_tx_pos   <= n_tx_pos;
            r_wr_act   <= n_wr_act;
            r_rd_act   <= n_rd_act;
            r_last_rd  <= n_last_rd;
            r_s2_valid <= o_take;
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(BUF_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s2_src   <= n_src;
            r_s2_note  <= n_note;
            r_s2_ovf   <= n_ovf;
            r_s2_count <= 11'(n_rx_fill);
        end
    end

    itmb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_we),
        .i_waddr (w_rx_waddr),
        .i_wdata (i_op.data),
        .i_re    (w_rx_re),
        .i_raddr (w_rx_raddr),
        .o_rdata (w_rx_rdata)
    );

    itmb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (w_tx_waddr),
        .i_wdata (w_tx_wdata),
        .i_re    (w_tx_re),
        .i_raddr (w_tx_raddr),
        .o_rdata (w_tx_rdata)
    );

    always_comb begin
        case (r_s2_src)
            SRC_TX:  o_res.read_byte = w_tx_rdata;
            SRC_RX:  o_res.read_byte = w_rx_rdata;
            SRC_FF:  o_res.read_byte = BYTE_FF;
            default: o_res.read_byte = 8'h00;
        endcase
        o_res.notify      = r_s2_note;
        o_res.rx_overflow = r_s2_ovf;
        o_res.rx_count    = r_s2_count;
    end

    assign o_res_valid = r_s2_valid;
    assign o_clr_busy  = r_clr_busy;

endmodule

FILE: rtl/itmb_outq.sv
module itmb_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  itmb_pkg::t_result          i_res,
    output logic [itmb_pkg::OQ_CW-1:0] o_cnt,
    output logic                       o_empty,
    input  logic                       i_pop,
    output itmb_pkg::t_result          o_res
);
    import itmb_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr;
    logic [OQ_AW-1:0] r_rd;
    logic [OQ_CW-1:0] r_cnt;
    logic [OQ_CW-1:0] n_cnt;
    logic             w_pop_ok;

    assign o_empty  = r_cnt == '0;
    assign w_pop_ok = i_pop && !o_empty;
    assign o_cnt    = r_cnt;
    assign o_res    = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

FILE: rtl/i2c_target_mailbox_buffer_top.sv
// path: front queue, then execute stage registers, then output queue
// throughput: one request per cycle while the output queue has room; the tx
// store port and the rx store port each serve one access per request in the
// execute stage; reset: synchronous, active low, after which full stays high
// while the tx store is swept to its initial contents
`include "assert_macros.svh"

module i2c_target_mailbox_buffer_top #(
    parameter int BUF_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_data,
    input  logic        i_first_byte,
    input  logic        i_bus_active,
    input  logic [9:0]  i_index,
    input  logic [10:0] i_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_notify,
    output logic        o_rx_overflow,
    output logic [10:0] o_rx_count
);
    import itmb_pkg::*;

    logic             w_op_valid;
    t_op              w_op;
    logic             w_take;
    logic [OQ_CW-1:0] w_outq_cnt;
    logic             w_res_valid;
    t_result          w_res;
    t_result          w_head;
    logic             w_clr_busy;

    itmb_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_hold       (w_clr_busy),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_data       (i_data),
        .i_first_byte (i_first_byte),
        .i_bus_active (i_bus_active),
        .i_index      (i_index),
        .i_length     (i_length),
        .o_op_valid   (w_op_valid),
        .o_op         (w_op),
        .i_take       (w_take)
    );

    itmb_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .i_op        (w_op),
        .o_take      (w_take),
        .i_outq_cnt  (w_outq_cnt),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_clr_busy  (w_clr_busy)
    );

    itmb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_cnt   (w_outq_cnt),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_head)
    );

    assign o_read_byte   = w_head.read_byte;
    assign o_notify      = w_head.notify;
    assign o_rx_overflow = w_head.rx_overflow;
    assign o_rx_count    = w_head.rx_count;

    `ASSERT_NEVER(a_no_take_in_sweep, i_clk, i_rst_n, w_clr_busy && w_take)
    `ASSERT_CLK(a_take_gives_result, i_clk, i_rst_n, w_take |=> w_res_valid)
    `ASSERT_CLK(a_outq_bound, i_clk, i_rst_n, w_outq_cnt <= OQ_CW'(OQ_DEPTH))

endmodule
